[rtl/int8_sparse_mlp_inference_defines.svh]
// assertion macros for the sparse mlp block
// used by the port checker, no other dependencies
`ifndef INT8_SPARSE_MLP_INFERENCE_DEFINES_SVH
`define INT8_SPARSE_MLP_INFERENCE_DEFINES_SVH

// same-cycle implication
`define SMLP_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smlp check failed");

// next-cycle implication
`define SMLP_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smlp check failed");

`endif

[rtl/smlp_pkg.sv]
// shared types, codes and arithmetic helpers of the sparse mlp block
// no dependencies
package smlp_pkg;

	localparam int DEF_FIRST_HIDDEN = 64;
	localparam int DEF_SECOND_HIDDEN = 32;
	localparam int DEF_FEATURE_COUNT = 200;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_ADD = 2'd1;
	localparam logic [1:0] MODE_EVAL = 2'd2;

	localparam logic [1:0] REG_SCALE_ONE = 2'd0;
	localparam logic [1:0] REG_SCALE_TWO = 2'd1;
	localparam logic [1:0] REG_SCALE_OUT = 2'd2;

	localparam logic [31:0] SCALE_RESET = 32'h0100_0000;
	localparam logic [5:0] SQUARE_MAX = 6'd49;
	localparam logic [39:0] SCORE_LIMIT = 40'd29000;
	localparam logic [63:0] SAT_Q24 = 64'd253 << 23;
	localparam logic [63:0] HALF_Q24 = 64'd1 << 23;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACC_ADD,
		OP_L1,
		OP_MAC,
		OP_L2_END,
		OP_FINAL
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_L1,
		ST_WAIT1,
		ST_L2,
		ST_L2_END,
		ST_WAIT2,
		ST_FINAL
	} state_t;

	typedef struct packed {
		logic take;
		op_t op;
		logic [7:0] j;
		logic [6:0] k;
		logic first;
	} cmd_t;

	typedef struct packed {
		logic feat_ok;
		logic busy;
		logic out_pend;
	} stat_t;

	function automatic logic [6:0] requant(input logic pos, input logic [63:0] p);
		logic [63:0] r;
		r = p + HALF_Q24;
		if (!pos)
			return 7'd0;
		else if (p >= SAT_Q24)
			return 7'd127;
		else
			return r[30:24];
	endfunction

endpackage

[rtl/smlp_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module smlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/smlp_ctrl.sv]
// sequencer of the sparse mlp block: item accept and per-cycle commands
// depends on smlp_pkg
module smlp_ctrl import smlp_pkg::*; #(
	parameter int FIRST_HIDDEN = DEF_FIRST_HIDDEN,
	parameter int SECOND_HIDDEN = DEF_SECOND_HIDDEN
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  stat_t      stat,
	output cmd_t       cmd
);

	state_t state_q, state_nx;
	logic [7:0] j_q;
	logic [6:0] k_q;
	logic take, j_last, k_last;

	assign take = in_valid && (state_q == ST_IDLE);
	assign j_last = j_q == 8'(FIRST_HIDDEN - 1);
	assign k_last = k_q == 7'(SECOND_HIDDEN - 1);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && mode == MODE_ADD && stat.feat_ok)
					state_nx = ST_ADD;
				else if (take && mode == MODE_EVAL)
					state_nx = ST_L1;
			end
			ST_ADD: begin
				if (j_last)
					state_nx = ST_IDLE;
			end
			ST_L1: begin
				if (j_last)
					state_nx = ST_WAIT1;
			end
			ST_WAIT1: begin
				if (!stat.busy)
					state_nx = ST_L2;
			end
			ST_L2: begin
				if (j_last)
					state_nx = ST_L2_END;
			end
			ST_L2_END: begin
				state_nx = k_last ? ST_WAIT2 : ST_L2;
			end
			ST_WAIT2: begin
				if (!stat.busy && !stat.out_pend)
					state_nx = ST_FINAL;
			end
			ST_FINAL: begin
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.take = take;
		cmd.op = OP_NOP;
		cmd.j = j_q;
		cmd.k = k_q;
		cmd.first = j_q == 8'd0;
		in_stall = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: cmd.op = OP_NOP;
			ST_ADD: cmd.op = OP_ACC_ADD;
			ST_L1: cmd.op = OP_L1;
			ST_WAIT1: cmd.op = OP_NOP;
			ST_L2: cmd.op = OP_MAC;
			ST_L2_END: cmd.op = OP_L2_END;
			ST_WAIT2: cmd.op = OP_NOP;
			ST_FINAL: cmd.op = OP_FINAL;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			j_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q) inside
				ST_ADD, ST_L1, ST_L2: j_q <= j_last ? 8'd0 : j_q + 8'd1;
				ST_L2_END: k_q <= k_q + 7'd1;
				ST_IDLE, ST_WAIT1, ST_WAIT2, ST_FINAL: begin
					j_q <= '0;
					k_q <= '0;
				end
				default: j_q <= '0;
			endcase
		end
	end

endmodule

[rtl/smlp_dp.sv]
// datapath of the sparse mlp block: weight stores, accumulators, mac and scaling
// depends on smlp_pkg and smlp_ram
module smlp_dp import smlp_pkg::*; #(
	parameter int FIRST_HIDDEN = DEF_FIRST_HIDDEN,
	parameter int SECOND_HIDDEN = DEF_SECOND_HIDDEN,
	parameter int FEATURE_COUNT = DEF_FEATURE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [1:0]         mode,
	input  logic [13:0]        weight_address,
	input  logic signed [31:0] weight_value,
	input  logic [5:0]         square,
	input  logic [1:0]         piece_kind,
	input  logic               black_to_move,
	input  logic [31:0]        scale_one,
	input  logic [31:0]        scale_two,
	input  logic [31:0]        scale_out,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] score
);

	localparam int W1_D = FIRST_HIDDEN * FEATURE_COUNT;
	localparam int W2_D = SECOND_HIDDEN * FIRST_HIDDEN;
	localparam int B1_BASE = W1_D;
	localparam int W2_BASE = B1_BASE + FIRST_HIDDEN;
	localparam int B2_BASE = W2_BASE + W2_D;
	localparam int W3_BASE = B2_BASE + SECOND_HIDDEN;
	localparam int B3_BASE = W3_BASE + SECOND_HIDDEN;
	localparam int AW1 = $clog2(W1_D);
	localparam int AW2 = $clog2(W2_D);
	localparam int HW = $clog2(FIRST_HIDDEN);
	localparam int KW = $clog2(SECOND_HIDDEN);

	logic [31:0] wa;
	logic wr;
	logic [5:0] sq_eff;
	logic [1:0] kind_eff;
	logic [7:0] feat;
	logic [7:0] feat_q;
	logic [31:0] b3_q;

	logic [7:0] w1_rd, w2_rd, w3_rd;
	logic [31:0] b1_rd, b2_rd, acc_rd;
	logic [6:0] hb_rd;
	logic acc_we, hb_we;
	logic [31:0] acc_wdata, acc_val;
	logic [6:0] h_val;
	logic [FIRST_HIDDEN-1:0] acc_vld_q;

	cmd_t cmd_s1, cmd_s2, cmd_s3;
	logic vld_s1;
	logic [31:0] sum_s2, b2_s2;
	logic signed [15:0] prod_s2;
	logic [7:0] w3_s2, w3_s3;
	logic [63:0] p_s3;
	logic pos_s3, neg_s3;
	logic signed [15:0] prod3_s4;
	logic l3_s4;
	logic [31:0] acc2_q, acc3_q;
	logic [31:0] m_a, m_b, m_sel;
	logic m_pos, m_neg;
	logic [39:0] q_clamp;
	logic [15:0] q16;
	logic out_valid_q;
	logic [15:0] score_q;

	assign wa = 32'(weight_address);
	assign wr = cmd.take && mode == MODE_WRITE;
	assign sq_eff = black_to_move ? SQUARE_MAX - square : square;
	assign kind_eff = black_to_move ? (piece_kind ^ 2'b10) : piece_kind;
	assign feat = {sq_eff, kind_eff};
	assign stat.feat_ok = square <= SQUARE_MAX && 32'(feat) < 32'(FEATURE_COUNT);
	assign stat.busy = cmd_s1.op != OP_NOP || cmd_s2.op != OP_NOP ||
		cmd_s3.op != OP_NOP || l3_s4;
	assign stat.out_pend = out_valid_q;

	smlp_ram #(.WIDTH(8), .DEPTH(W1_D)) u_w1 (
		.clk(clk), .we(wr && wa < 32'(B1_BASE)), .waddr(AW1'(wa)),
		.wdata(weight_value[7:0]),
		.raddr(AW1'(32'(cmd.j) * 32'(FEATURE_COUNT) + 32'(feat_q))),
		.rdata(w1_rd)
	);

	smlp_ram #(.WIDTH(32), .DEPTH(FIRST_HIDDEN)) u_b1 (
		.clk(clk), .we(wr && wa >= 32'(B1_BASE) && wa < 32'(W2_BASE)),
		.waddr(HW'(wa - 32'(B1_BASE))), .wdata(weight_value),
		.raddr(cmd.j[HW-1:0]), .rdata(b1_rd)
	);

	smlp_ram #(.WIDTH(8), .DEPTH(W2_D)) u_w2 (
		.clk(clk), .we(wr && wa >= 32'(W2_BASE) && wa < 32'(B2_BASE)),
		.waddr(AW2'(wa - 32'(W2_BASE))), .wdata(weight_value[7:0]),
		.raddr(AW2'(32'(cmd.k) * 32'(FIRST_HIDDEN) + 32'(cmd.j))),
		.rdata(w2_rd)
	);

	smlp_ram #(.WIDTH(32), .DEPTH(SECOND_HIDDEN)) u_b2 (
		.clk(clk), .we(wr && wa >= 32'(B2_BASE) && wa < 32'(W3_BASE)),
		.waddr(KW'(wa - 32'(B2_BASE))), .wdata(weight_value),
		.raddr(cmd.k[KW-1:0]), .rdata(b2_rd)
	);

	smlp_ram #(.WIDTH(8), .DEPTH(SECOND_HIDDEN)) u_w3 (
		.clk(clk), .we(wr && wa >= 32'(W3_BASE) && wa < 32'(B3_BASE)),
		.waddr(KW'(wa - 32'(W3_BASE))), .wdata(weight_value[7:0]),
		.raddr(cmd.k[KW-1:0]), .rdata(w3_rd)
	);

	smlp_ram #(.WIDTH(32), .DEPTH(FIRST_HIDDEN)) u_acc (
		.clk(clk), .we(acc_we), .waddr(cmd_s1.j[HW-1:0]), .wdata(acc_wdata),
		.raddr(cmd.j[HW-1:0]), .rdata(acc_rd)
	);

	smlp_ram #(.WIDTH(7), .DEPTH(FIRST_HIDDEN)) u_hb (
		.clk(clk), .we(hb_we), .waddr(cmd_s3.j[HW-1:0]), .wdata(h_val),
		.raddr(cmd.j[HW-1:0]), .rdata(hb_rd)
	);

	assign acc_val = vld_s1 ? acc_rd : 32'd0;
	assign acc_we = cmd_s1.op == OP_ACC_ADD;
	assign acc_wdata = acc_val + {{24{w1_rd[7]}}, w1_rd};

	always_comb begin
		m_sel = sum_s2;
		m_b = scale_one;
		case (cmd_s2.op)
			OP_L2_END: begin
				m_sel = acc2_q;
				m_b = scale_two;
			end
			OP_FINAL: begin
				m_sel = acc3_q;
				m_b = scale_out;
			end
			default: begin
				m_sel = sum_s2;
				m_b = scale_one;
			end
		endcase
		m_pos = !m_sel[31] && m_sel != 32'd0;
		m_neg = m_sel[31];
		if (cmd_s2.op == OP_FINAL)
			m_a = m_neg ? 32'd0 - m_sel : m_sel;
		else
			m_a = m_pos ? m_sel : 32'd0;
	end

	assign h_val = requant(pos_s3, p_s3);
	assign hb_we = cmd_s3.op == OP_L1;
	assign q_clamp = (p_s3[63:24] > SCORE_LIMIT) ? SCORE_LIMIT : p_s3[63:24];
	assign q16 = q_clamp[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
			cmd_s3 <= '0;
			l3_s4 <= 1'b0;
			acc_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
			cmd_s3 <= cmd_s2;
			l3_s4 <= cmd_s3.op == OP_L2_END;
			if (cmd.op == OP_FINAL)
				acc_vld_q <= '0;
			else if (acc_we)
				acc_vld_q[cmd_s1.j[HW-1:0]] <= 1'b1;
			if (cmd_s3.op == OP_FINAL)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && mode == MODE_ADD)
			feat_q <= feat;
		if (wr && wa == 32'(B3_BASE))
			b3_q <= weight_value;
		vld_s1 <= acc_vld_q[cmd.j[HW-1:0]];
		sum_s2 <= acc_val + b1_rd;
		b2_s2 <= b2_rd;
		w3_s2 <= w3_rd;
		prod_s2 <= $signed(w2_rd) * $signed({1'b0, hb_rd});
		p_s3 <= 64'(m_a) * 64'(m_b);
		pos_s3 <= m_pos;
		neg_s3 <= m_neg;
		w3_s3 <= w3_s2;
		prod3_s4 <= $signed(w3_s3) * $signed({1'b0, h_val});
		if (cmd_s2.op == OP_MAC)
			acc2_q <= (cmd_s2.first ? b2_s2 : acc2_q) + 32'(prod_s2);
		if (cmd.op == OP_L1 && cmd.first)
			acc3_q <= b3_q;
		else if (l3_s4)
			acc3_q <= acc3_q + 32'(prod3_s4);
		if (cmd_s3.op == OP_FINAL)
			score_q <= neg_s3 ? 16'd0 - q16 : q16;
	end

	assign out_valid = out_valid_q;
	assign score = score_q;

endmodule

[rtl/int8_sparse_mlp_inference.sv]
// weight write: stored when taken; feature add: one accumulator a cycle over FIRST_HIDDEN
// evaluate: layer one over FIRST_HIDDEN, a wait, SECOND_HIDDEN layer two outputs, a wait and a
// final step; after the final step, cmd_s1, cmd_s2 and cmd_s3 lie before the score register
// throughput: one item at a time, the next is taken once the sequencer is idle
// reset: control and accumulator valid bits clear, scale registers load SCALE_RESET at once;
// weight stores keep undefined contents until written
module int8_sparse_mlp_inference import smlp_pkg::*; #(
	parameter int FIRST_HIDDEN = DEF_FIRST_HIDDEN,
	parameter int SECOND_HIDDEN = DEF_SECOND_HIDDEN,
	parameter int FEATURE_COUNT = DEF_FEATURE_COUNT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [13:0]        weight_address,
	input  logic signed [31:0] weight_value,
	input  logic [5:0]         square,
	input  logic [1:0]         piece_kind,
	input  logic               black_to_move,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] score,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [31:0] scale_one_q, scale_two_q, scale_out_q;
	logic cfg_wr;
	cmd_t cmd;
	stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_one_q <= SCALE_RESET;
			scale_two_q <= SCALE_RESET;
			scale_out_q <= SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_SCALE_ONE: scale_one_q <= pwdata;
				REG_SCALE_TWO: scale_two_q <= pwdata;
				REG_SCALE_OUT: scale_out_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_SCALE_ONE: prdata = scale_one_q;
			REG_SCALE_TWO: prdata = scale_two_q;
			REG_SCALE_OUT: prdata = scale_out_q;
			default: prdata = 32'd0;
		endcase
	end

	smlp_ctrl #(
		.FIRST_HIDDEN(FIRST_HIDDEN),
		.SECOND_HIDDEN(SECOND_HIDDEN)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .stat(stat), .cmd(cmd)
	);

	smlp_dp #(
		.FIRST_HIDDEN(FIRST_HIDDEN),
		.SECOND_HIDDEN(SECOND_HIDDEN),
		.FEATURE_COUNT(FEATURE_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .mode(mode),
		.weight_address(weight_address), .weight_value(weight_value),
		.square(square), .piece_kind(piece_kind), .black_to_move(black_to_move),
		.scale_one(scale_one_q), .scale_two(scale_two_q), .scale_out(scale_out_q),
		.out_valid(out_valid), .out_stall(out_stall), .score(score)
	);

endmodule

[rtl/smlp_checker.sv]
// port-level checker of the sparse mlp block and its bind
// depends on smlp_pkg and int8_sparse_mlp_inference_defines.svh
`include "int8_sparse_mlp_inference_defines.svh"
module smlp_checker import smlp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         mode,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] score,
	input logic               pready
);

	`SMLP_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(score))
	`SMLP_AST_NOW(a_score_range, out_valid, score <= 16'sd29000 && score >= -16'sd29000)
	`SMLP_AST_NEXT(a_eval_busy, in_valid && !in_stall && mode == MODE_EVAL, in_stall)
	`SMLP_AST_NOW(a_pready, 1'b1, pready)

endmodule

bind int8_sparse_mlp_inference smlp_checker u_smlp_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.mode(mode), .out_valid(out_valid), .out_stall(out_stall), .score(score),
	.pready(pready)
);
